### sv/cfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

    // Field widths of the edge term and the face result.
    localparam int E_W    = 32;   // E samples, signed Q16.16
    localparam int LEN_W  = 32;   // lengths and area, unsigned Q16.16
    localparam int OFS_W  = 16;   // centroid offset, signed Q1.15
    localparam int SUM_W  = 64;   // circulation accumulator
    localparam int SLP_W  = E_W + 2;          // doubled slope
    localparam int PRD_W  = OFS_W + SLP_W;    // offset times doubled slope
    localparam int SHF_W  = PRD_W - OFS_W;    // shift after dropping Q1.15 scale
    localparam int ADJ_W  = SHF_W + 1;        // E plus shift before clipping

    // Divider: one quotient bit per cycle over the whole dividend.
    localparam int DIV_ITERS = SUM_W;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    // One half in the scale of the product, for round half up.
    localparam logic signed [PRD_W-1:0] ROUND_HALF = PRD_W'(1) <<< (OFS_W - 1);

    // Saturation limits of the Q16.16 result and of the 64-bit circulation sum.
    localparam logic [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
    localparam logic [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic slope;
        logic mul_d;
        logic adj;
        logic mul_t;
        logic acc;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cfc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic area_zero;
        logic div_last;
    } t_cfc_sts;

endpackage

`default_nettype wire

### sv/cfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cfc_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    input  cfc_pkg::t_cfc_sts     i_sts,
    output cfc_pkg::t_cfc_cmd     o_cmd
);
    import cfc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SLOPE = 4'd1;
    localparam logic [3:0] S_MULD  = 4'd2;
    localparam logic [3:0] S_ADJ   = 4'd3;
    localparam logic [3:0] S_MULT  = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_PREP  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_take;
    logic       out_free;

    // Input is taken only between edge terms; the output register drains on its own.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SLOPE;
                end
            end
            S_SLOPE: begin
                o_cmd.slope = 1'b1;
                n_state     = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_ADJ;
            end
            S_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state   = S_MULT;
            end
            S_MULT: begin
                o_cmd.mul_t = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state        = i_sts.area_zero ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a load, cleared when the transaction completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### sv/cfc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module cfc_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire                                  i_cfg_wdata,
    input  cfc_pkg::t_cfc_cmd                    i_cmd,
    output cfc_pkg::t_cfc_sts                    o_sts,
    input  wire signed [cfc_pkg::E_W-1:0]        i_e_center,
    input  wire signed [cfc_pkg::E_W-1:0]        i_e_next,
    input  wire signed [cfc_pkg::E_W-1:0]        i_e_prev,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_len_center,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_len_next,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_len_prev,
    input  wire signed [cfc_pkg::OFS_W-1:0]      i_centroid_offset,
    input  wire                                  i_negate,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_face_area,
    input  wire                                  i_last,
    output logic signed [cfc_pkg::E_W-1:0]       o_emf_value,
    output logic                                 o_updated,
    output logic                                 o_saturated
);
    import cfc_pkg::*;

    // Configuration and captured edge term.
    logic                     r_cfg;
    logic signed [E_W-1:0]    r_e;
    logic signed [E_W-1:0]    r_en;
    logic signed [E_W-1:0]    r_ep;
    logic        [LEN_W-1:0]  r_len;
    logic                     r_next_open;
    logic                     r_prev_open;
    logic signed [OFS_W-1:0]  r_delta;
    logic                     r_neg;
    logic        [LEN_W-1:0]  r_area;
    logic                     r_last;

    // Pipeline of the term computation.
    logic signed [SLP_W-1:0]  r_slope2;
    logic signed [SLP_W-1:0]  n_slope2;
    logic signed [PRD_W-1:0]  r_prod_d;
    logic signed [E_W-1:0]    r_e_adj;
    logic signed [E_W-1:0]    n_e_adj;
    logic                     n_adj_clip;
    logic signed [SUM_W-1:0]  r_prod_t;
    logic signed [SUM_W:0]    n_prod_t;

    // Face state.
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     n_acc_clip;
    logic                     r_clip;

    // Divider.
    logic        [SUM_W-1:0]  r_div_n;
    logic        [LEN_W-1:0]  r_div_rem;
    logic        [CNT_W-1:0]  r_div_cnt;
    logic                     r_div_neg;
    logic        [SUM_W-1:0]  n_dividend;
    logic        [LEN_W:0]    n_rem_sh;
    logic                     n_qbit;
    logic        [LEN_W-1:0]  n_rem;

    // Result.
    logic signed [E_W-1:0]    n_emf;
    logic                     n_qsat;

    logic signed [E_W:0]      d_np;
    logic signed [E_W:0]      d_nc;
    logic signed [E_W:0]      d_cp;
    logic signed [PRD_W-1:0]  prod_rnd;
    logic signed [SHF_W-1:0]  shift_v;
    logic signed [ADJ_W-1:0]  adj_v;
    logic        [SUM_W:0]    acc_v;
    logic        [LEN_W-1:0]  half_area;

    assign o_sts.last      = r_last;
    assign o_sts.area_zero = (r_area == '0);
    assign o_sts.div_last  = (r_div_cnt == '0);

    // Doubled slope: centred, one-sided, or zero when no shift applies.
    always_comb begin
        d_np = {r_en[E_W-1], r_en} - {r_ep[E_W-1], r_ep};
        d_nc = {r_en[E_W-1], r_en} - {r_e[E_W-1], r_e};
        d_cp = {r_e[E_W-1], r_e} - {r_ep[E_W-1], r_ep};
        priority if (!r_cfg || r_delta == '0) begin
            n_slope2 = '0;
        end else if (r_next_open && r_prev_open) begin
            n_slope2 = {d_np[E_W], d_np};
        end else if (r_next_open) begin
            n_slope2 = {d_nc, 1'b0};
        end else if (r_prev_open) begin
            n_slope2 = {d_cp, 1'b0};
        end else begin
            n_slope2 = '0;
        end
    end

    // Shifted E: round half up, drop the Q1.15 scale, clip to 32 bits.
    always_comb begin
        prod_rnd   = r_prod_d + ROUND_HALF;
        shift_v    = prod_rnd[PRD_W-1:OFS_W];
        adj_v      = {{(ADJ_W-E_W){r_e[E_W-1]}}, r_e} + {shift_v[SHF_W-1], shift_v};
        n_adj_clip = 1'b0;
        n_e_adj    = adj_v[E_W-1:0];
        if (!adj_v[ADJ_W-1] && (adj_v[ADJ_W-2:E_W-1] != '0)) begin
            n_e_adj    = E_MAX;
            n_adj_clip = 1'b1;
        end else if (adj_v[ADJ_W-1] && (adj_v[ADJ_W-2:E_W-1] != '1)) begin
            n_e_adj    = E_MIN;
            n_adj_clip = 1'b1;
        end
    end

    // Edge term: signed E times unsigned length.
    assign n_prod_t = r_e_adj * $signed({1'b0, r_len});

    // Saturating add or subtract of the term into the circulation.
    always_comb begin
        if (r_neg) begin
            acc_v = {r_sum[SUM_W-1], r_sum} - {r_prod_t[SUM_W-1], r_prod_t};
        end else begin
            acc_v = {r_sum[SUM_W-1], r_sum} + {r_prod_t[SUM_W-1], r_prod_t};
        end
        n_acc_clip = acc_v[SUM_W] ^ acc_v[SUM_W-1];
        if (n_acc_clip) begin
            n_sum = acc_v[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = acc_v[SUM_W-1:0];
        end
    end

    // Rounded dividend: magnitude of the sum plus half the area.
    always_comb begin
        half_area = {1'b0, r_area[LEN_W-1:1]};
        if (r_sum[SUM_W-1]) begin
            n_dividend = ~r_sum + {{(SUM_W-LEN_W){1'b0}}, half_area + LEN_W'(1)};
        end else begin
            n_dividend = r_sum + {{(SUM_W-LEN_W){1'b0}}, half_area};
        end
    end

    // One restoring division step.
    always_comb begin
        n_rem_sh = {r_div_rem, r_div_n[SUM_W-1]};
        n_qbit   = (n_rem_sh >= {1'b0, r_area});
        if (n_qbit) begin
            n_rem = LEN_W'(n_rem_sh - {1'b0, r_area});
        end else begin
            n_rem = n_rem_sh[LEN_W-1:0];
        end
    end

    // Signed quotient, clipped to the Q16.16 range.
    always_comb begin
        n_qsat = 1'b0;
        n_emf  = '0;
        if (!r_div_neg) begin
            if (r_div_n[SUM_W-1:E_W-1] != '0) begin
                n_qsat = 1'b1;
                n_emf  = E_MAX;
            end else begin
                n_emf = r_div_n[E_W-1:0];
            end
        end else begin
            if ((r_div_n[SUM_W-1:E_W] != '0)
                || (r_div_n[E_W-1] && (r_div_n[E_W-2:0] != '0))) begin
                n_qsat = 1'b1;
                n_emf  = E_MIN;
            end else begin
                n_emf = -r_div_n[E_W-1:0];
            end
        end
    end

    // Configuration and face state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= 1'b0;
            r_sum  <= '0;
            r_clip <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.load_out) begin
                r_sum  <= '0;
                r_clip <= 1'b0;
            end else begin
                if (i_cmd.acc) begin
                    r_sum <= n_sum;
                end
                if ((i_cmd.adj && n_adj_clip) || (i_cmd.acc && n_acc_clip)) begin
                    r_clip <= 1'b1;
                end
            end
        end
    end

    // Capture and term pipeline.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_e         <= i_e_center;
            r_en        <= i_e_next;
            r_ep        <= i_e_prev;
            r_len       <= i_len_center;
            r_next_open <= (i_len_next != '0);
            r_prev_open <= (i_len_prev != '0);
            r_delta     <= i_centroid_offset;
            r_neg       <= i_negate;
            r_area      <= i_face_area;
            r_last      <= i_last;
        end
        if (i_cmd.slope) begin
            r_slope2 <= n_slope2;
        end
        if (i_cmd.mul_d) begin
            r_prod_d <= r_delta * r_slope2;
        end
        if (i_cmd.adj) begin
            r_e_adj <= n_e_adj;
        end
        if (i_cmd.mul_t) begin
            r_prod_t <= n_prod_t[SUM_W-1:0];
        end
    end

    // Divider registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div_n   <= n_dividend;
            r_div_rem <= '0;
            r_div_cnt <= CNT_W'(DIV_ITERS - 1);
            r_div_neg <= r_sum[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_div_n   <= {r_div_n[SUM_W-2:0], n_qbit};
            r_div_rem <= n_rem;
            r_div_cnt <= r_div_cnt - CNT_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_area == '0) begin
                o_emf_value <= '0;
                o_updated   <= 1'b0;
                o_saturated <= 1'b0;
            end else begin
                o_emf_value <= n_emf;
                o_updated   <= 1'b1;
                o_saturated <= r_clip || n_qsat;
            end
        end
    end

endmodule

`default_nettype wire

### sv/conformal_face_circulation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// An edge term that is not last passes through capture, slope, offset multiply, clipping,
// term multiply and accumulate. A last term with nonzero area then goes through a setup
// step, the divider, which forms all 64 quotient bits, and an output load; with zero area
// the divider is skipped. The block takes no new term until it is idle again, and the output
// load waits while the output register holds a stalled result. Synchronous active-low
// reset clears the sum, clip flag, curvature register, controller and output valid.

module conformal_face_circulation_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire                                  i_cfg_wdata,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire signed [cfc_pkg::E_W-1:0]        i_e_center,
    input  wire signed [cfc_pkg::E_W-1:0]        i_e_next,
    input  wire signed [cfc_pkg::E_W-1:0]        i_e_prev,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_len_center,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_len_next,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_len_prev,
    input  wire signed [cfc_pkg::OFS_W-1:0]      i_centroid_offset,
    input  wire                                  i_negate,
    input  wire        [cfc_pkg::LEN_W-1:0]      i_face_area,
    input  wire                                  i_last,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic signed [cfc_pkg::E_W-1:0]       o_emf_value,
    output logic                                 o_updated,
    output logic                                 o_saturated
);
    import cfc_pkg::*;

    t_cfc_cmd cmd;
    t_cfc_sts sts;

    // Sequencer for one edge term and the face division.
    cfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic, accumulator, divider and output register.
    cfc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_e_center        (i_e_center),
        .i_e_next          (i_e_next),
        .i_e_prev          (i_e_prev),
        .i_len_center      (i_len_center),
        .i_len_next        (i_len_next),
        .i_len_prev        (i_len_prev),
        .i_centroid_offset (i_centroid_offset),
        .i_negate          (i_negate),
        .i_face_area       (i_face_area),
        .i_last            (i_last),
        .o_emf_value       (o_emf_value),
        .o_updated         (o_updated),
        .o_saturated       (o_saturated)
    );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import cfc_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          TAIL_CYCLES   = 100;
    localparam int          CYCLE_LIMIT   = 500_000;
    localparam int          PRINT_LIMIT   = 40;
    localparam int          RAND_PHASES   = 5;
    localparam int          PHASE_TERMS   = 170;
    // Per random phase: curvature setting and whether the two sides idle.
    localparam logic [4:0]  PHASE_CURV    = 5'b10110;
    localparam logic [4:0]  PHASE_IDLE    = 5'b01101;
    localparam bit          CURV_OFF      = 1'b0;
    localparam bit          CURV_ON       = 1'b1;

    localparam logic [31:0] UNIT     = 32'h0001_0000;  // 1.0 in Q16.16
    localparam logic [15:0] OFS_HALF = 16'h4000;       // 0.5 in Q1.15
    localparam logic [15:0] OFS_MAX  = 16'h7FFF;
    localparam logic [15:0] OFS_MIN  = 16'h8000;
    localparam longint      E_TOP    = 64'sd2147483647;
    localparam longint      E_BOT    = -64'sd2147483648;
    localparam longint      SUM_TOP  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      SUM_BOT  = 64'sh8000_0000_0000_0000;

    // One edge term of a face, as it crosses the input port.
    typedef struct packed {
        logic signed [E_W-1:0]   e_center;
        logic signed [E_W-1:0]   e_next;
        logic signed [E_W-1:0]   e_prev;
        logic        [LEN_W-1:0] len_center;
        logic        [LEN_W-1:0] len_next;
        logic        [LEN_W-1:0] len_prev;
        logic signed [OFS_W-1:0] offset;
        logic                    negate;
        logic        [LEN_W-1:0] face_area;
        logic                    last;
    } t_edge_term;

    typedef struct packed {
        logic signed [E_W-1:0] emf;
        logic                  updated;
        logic                  saturated;
    } t_face_emf;

    typedef enum logic [1:0] {ROW_CHECKED, ROW_TYPED, ROW_CURVATURE} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic       curv;
        t_edge_term term;
        t_face_emf  want;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic                     i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [E_W-1:0]    i_e_center;
    logic signed [E_W-1:0]    i_e_next;
    logic signed [E_W-1:0]    i_e_prev;
    logic        [LEN_W-1:0]  i_len_center;
    logic        [LEN_W-1:0]  i_len_next;
    logic        [LEN_W-1:0]  i_len_prev;
    logic signed [OFS_W-1:0]  i_centroid_offset;
    logic                     i_negate;
    logic        [LEN_W-1:0]  i_face_area;
    logic                     i_last;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [E_W-1:0]    o_emf_value;
    logic                     o_updated;
    logic                     o_saturated;

    // Predictor state and the face results still owed by the block.
    longint      circ_sum    = 0;
    bit          clip_seen   = 1'b0;
    bit          curv_en     = CURV_OFF;
    t_face_emf   pending_emf[$];
    t_stim_row   dir_rows[$];
    int          mismatches  = 0;
    int unsigned cycles      = 0;
    int unsigned stall_left  = 0;
    bit          idle_on     = 1'b1;

    conformal_face_circulation_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_e_center        (i_e_center),
        .i_e_next          (i_e_next),
        .i_e_prev          (i_e_prev),
        .i_len_center      (i_len_center),
        .i_len_next        (i_len_next),
        .i_len_prev        (i_len_prev),
        .i_centroid_offset (i_centroid_offset),
        .i_negate          (i_negate),
        .i_face_area       (i_face_area),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_emf_value       (o_emf_value),
        .o_updated         (o_updated),
        .o_saturated       (o_saturated)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // E moved to the uncovered centroid along the edge, clipped to 32 bits.
    function automatic longint edge_field(input t_edge_term t);
        longint e, en, ep, d, slope2, v;
        e  = $signed(t.e_center);
        en = $signed(t.e_next);
        ep = $signed(t.e_prev);
        d  = $signed(t.offset);
        if (curv_en == CURV_OFF || d == 0) return e;
        // Doubled slope: centered, one-sided, or none when both neighbors are covered.
        if (t.len_next != 0 && t.len_prev != 0) slope2 = en - ep;
        else if (t.len_next != 0)               slope2 = 2 * (en - e);
        else if (t.len_prev != 0)               slope2 = 2 * (e - ep);
        else                                    return e;
        v = e + ((d * slope2 + 64'sd32768) >>> 16);
        if (v > E_TOP) begin
            clip_seen = 1'b1;
            return E_TOP;
        end
        if (v < E_BOT) begin
            clip_seen = 1'b1;
            return E_BOT;
        end
        return v;
    endfunction

    // Adds one edge term to the circulation; on the last term gives the face EMF.
    function automatic bit fold_edge_term(input t_edge_term t, output t_face_emf res);
        longint           term;
        logic [SUM_W-1:0] mag, qm, area;
        bit               neg;
        res  = '0;
        term = edge_field(t) * $signed({32'd0, t.len_center});
        if (t.negate) term = -term;
        if (term > 0 && circ_sum > SUM_TOP - term) begin
            circ_sum  = SUM_TOP;
            clip_seen = 1'b1;
        end else if (term < 0 && circ_sum < SUM_BOT - term) begin
            circ_sum  = SUM_BOT;
            clip_seen = 1'b1;
        end else begin
            circ_sum = circ_sum + term;
        end
        if (!t.last) return 1'b0;

        // Divide by the area, rounding ties away from zero, then clip to Q16.16.
        if (t.face_area != 0) begin
            neg  = circ_sum < 0;
            mag  = neg ? -circ_sum : circ_sum;
            area = {32'd0, t.face_area};
            qm   = (mag + area / 2) / area;
            res.updated   = 1'b1;
            res.saturated = clip_seen;
            if (!neg && qm > 64'h7FFF_FFFF) begin
                qm            = 64'h7FFF_FFFF;
                res.saturated = 1'b1;
            end
            if (neg && qm > 64'h8000_0000) begin
                qm            = 64'h8000_0000;
                res.saturated = 1'b1;
            end
            res.emf = neg ? -qm[E_W-1:0] : qm[E_W-1:0];
        end
        circ_sum  = 0;
        clip_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_stim_row term_row(input t_row_kind kind,
            input logic [31:0] ec, en, ep, lc, ln, lp, input logic [15:0] ofs,
            input bit neg, input logic [31:0] area, input bit lst,
            input logic [31:0] w_emf = 32'd0, input bit w_upd = 1'b0,
            input bit w_sat = 1'b0);
        t_stim_row r;
        r      = '0;
        r.kind = kind;
        r.term = '{e_center: ec, e_next: en, e_prev: ep, len_center: lc, len_next: ln,
                   len_prev: lp, offset: ofs, negate: neg, face_area: area, last: lst};
        r.want = '{emf: w_emf, updated: w_upd, saturated: w_sat};
        return r;
    endfunction

    function automatic t_stim_row curv_row(input bit val);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_CURVATURE;
        r.curv = val;
        return r;
    endfunction

    // Random field values: mostly moderate magnitudes, with extremes and full range mixed in.
    function automatic logic signed [E_W-1:0] rand_e();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? E_MAX : E_MIN;
            1, 2:    return $urandom;
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom;
            2:       return '1;
            default: return $urandom_range(1, 32'h0002_0000);
        endcase
    endfunction

    function automatic t_edge_term rand_term(input bit lst);
        t_edge_term t;
        t.e_center   = rand_e();
        t.e_next     = rand_e();
        t.e_prev     = rand_e();
        t.len_center = rand_len();
        t.len_next   = rand_len();
        t.len_prev   = rand_len();
        case ($urandom_range(0, 7))
            0:       t.offset = '0;
            1:       t.offset = ($urandom_range(0, 1) != 0) ? OFS_MAX : OFS_MIN;
            default: t.offset = OFS_W'($urandom);
        endcase
        t.negate = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
            0, 1:    t.face_area = '0;
            2, 3:    t.face_area = $urandom;
            4:       t.face_area = '1;
            default: t.face_area = $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
        t.last = lst;
        return t;
    endfunction

    // Presents one edge term, after an optional gap, and returns once the input stall is low again.
    task automatic send_term(input t_edge_term t);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_e_center        <= t.e_center;
        i_e_next          <= t.e_next;
        i_e_prev          <= t.e_prev;
        i_len_center      <= t.len_center;
        i_len_next        <= t.len_next;
        i_len_prev        <= t.len_prev;
        i_centroid_offset <= t.offset;
        i_negate          <= t.negate;
        i_face_area       <= t.face_area;
        i_last            <= t.last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Waits for the block to go idle, then writes the curvature register.
    task automatic set_curvature(input bit val);
        i_in_valid <= 1'b0;
        while (pending_emf.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        curv_en = val;
    endtask

    // Output stall comes in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Each result transaction is checked against the oldest expected face EMF.
    always @(posedge i_clk) begin
        t_face_emf got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{emf: o_emf_value, updated: o_updated, saturated: o_saturated};
            if (pending_emf.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: unexpected face result: emf %h upd %b sat %b",
                             $time, got.emf, got.updated, got.saturated);
            end else begin
                want = pending_emf.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: face result mismatch: expected emf %h upd %b sat %b,",
                                 $time, want.emf, want.updated, want.saturated,
                                 " got emf %h upd %b sat %b",
                                 got.emf, got.updated, got.saturated);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("conformal_face_circulation_top test failed");
            $finish;
        end
    end

    initial begin
        t_face_emf   res;
        int unsigned n_sent, face_len;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= 1'b0;
        i_in_valid        <= 1'b0;
        i_e_center        <= '0;
        i_e_next          <= '0;
        i_e_prev          <= '0;
        i_len_center      <= '0;
        i_len_next        <= '0;
        i_len_prev        <= '0;
        i_centroid_offset <= '0;
        i_negate          <= 1'b0;
        i_face_area       <= '0;
        i_last            <= 1'b0;

        // Directed table. Curvature is off after reset, so the offset is ignored at first.
        dir_rows.push_back(term_row(ROW_TYPED, UNIT, 5 * UNIT, '0, UNIT, UNIT, UNIT, OFS_HALF,
                                    1'b0, UNIT, 1'b1, UNIT, 1'b1, 1'b0));
        dir_rows.push_back(term_row(ROW_TYPED, UNIT, '0, '0, UNIT, '0, '0, '0,
                                    1'b1, UNIT, 1'b1, 32'hFFFF_0000, 1'b1, 1'b0));
        // Zero area leaves the face alone.
        dir_rows.push_back(term_row(ROW_TYPED, UNIT, '0, '0, UNIT, '0, '0, '0,
                                    1'b0, '0, 1'b1, 32'd0, 1'b0, 1'b0));
        // Rounding: ties go away from zero.
        dir_rows.push_back(term_row(ROW_TYPED, 32'd1, '0, '0, 32'd1, '0, '0, '0,
                                    1'b0, 32'd2, 1'b1, 32'd1, 1'b1, 1'b0));
        dir_rows.push_back(term_row(ROW_TYPED, 32'hFFFF_FFFF, '0, '0, 32'd1, '0, '0, '0,
                                    1'b0, 32'd2, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0));
        dir_rows.push_back(term_row(ROW_TYPED, 32'd1, '0, '0, 32'd1, '0, '0, '0,
                                    1'b0, 32'd3, 1'b1, 32'd0, 1'b1, 1'b0));
        // Largest products clip the quotient.
        dir_rows.push_back(term_row(ROW_TYPED, E_MAX, '0, '0, '1, '0, '0, '0,
                                    1'b0, 32'd1, 1'b1, E_MAX, 1'b1, 1'b1));
        dir_rows.push_back(term_row(ROW_TYPED, E_MIN, '0, '0, '1, '0, '0, '0,
                                    1'b0, 32'd1, 1'b1, E_MIN, 1'b1, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, E_MIN, '0, '0, '1, '0, '0, '0,
                                    1'b1, '1, 1'b1));
        // The accumulator clips at the 64-bit range.
        dir_rows.push_back(term_row(ROW_CHECKED, E_MAX, '0, '0, '1, '0, '0, '0,
                                    1'b0, 32'hDEAD_BEEF, 1'b0));
        dir_rows.push_back(term_row(ROW_TYPED, E_MAX, '0, '0, '1, '0, '0, '0,
                                    1'b0, '1, 1'b1, E_MAX, 1'b1, 1'b1));
        // A clip inside the face flags the result even when the quotient is in range.
        dir_rows.push_back(term_row(ROW_CHECKED, E_MAX, '0, '0, '1, '0, '0, '0,
                                    1'b0, '0, 1'b0));
        dir_rows.push_back(term_row(ROW_CHECKED, E_MAX, '0, '0, '1, '0, '0, '0,
                                    1'b0, '0, 1'b0));
        dir_rows.push_back(term_row(ROW_CHECKED, E_MAX, '0, '0, '1, '0, '0, '0,
                                    1'b1, UNIT, 1'b1));
        // Multi-edge face; the area on the first terms must be ignored.
        dir_rows.push_back(term_row(ROW_CHECKED, 3 * UNIT, '0, '0, UNIT, '0, '0, '0,
                                    1'b0, 32'd7, 1'b0));
        dir_rows.push_back(term_row(ROW_CHECKED, 32'hFFFE_8000, '0, '0, 32'h0000_8000, '0, '0,
                                    '0, 1'b1, '0, 1'b0));
        dir_rows.push_back(term_row(ROW_CHECKED, 32'h0002_4000, '0, '0, 32'h0001_8000, '0, '0,
                                    '0, 1'b1, 32'h0003_0000, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, UNIT, '0, '0, UNIT, '0, '0, '0,
                                    1'b0, '1, 1'b1));
        // Curvature on: centered, one-sided, covered and zero-offset cases, and E clipping.
        dir_rows.push_back(curv_row(CURV_ON));
        dir_rows.push_back(term_row(ROW_CHECKED, '0, 2 * UNIT, '0, UNIT, UNIT, UNIT, OFS_HALF,
                                    1'b0, UNIT, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, UNIT, 3 * UNIT, 32'hDEAD_0000, UNIT, UNIT, '0,
                                    OFS_MIN, 1'b0, UNIT, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, UNIT, 32'h1234_0000, 32'hFFFF_0000, UNIT, '0,
                                    UNIT, OFS_MAX, 1'b0, UNIT, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, UNIT, 7 * UNIT, 5 * UNIT, UNIT, '0, '0,
                                    OFS_HALF, 1'b0, UNIT, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, UNIT, 7 * UNIT, 5 * UNIT, UNIT, UNIT, UNIT,
                                    '0, 1'b0, UNIT, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, E_MAX, E_MAX, E_MIN, UNIT, 32'd1, 32'd1,
                                    OFS_MAX, 1'b0, UNIT, 1'b1));
        dir_rows.push_back(term_row(ROW_CHECKED, E_MIN, E_MIN, E_MAX, UNIT, 32'd1, 32'd1,
                                    OFS_MAX, 1'b1, UNIT, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CURVATURE) begin
                set_curvature(dir_rows[i].curv);
            end else begin
                send_term(dir_rows[i].term);
                if (fold_edge_term(dir_rows[i].term, res))
                    pending_emf.push_back(dir_rows[i].kind == ROW_TYPED ? dir_rows[i].want : res);
            end
        end

        // Random faces of random length; each phase drains before its register write.
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_curvature(PHASE_CURV[p]);
            idle_on <= PHASE_IDLE[p];
            n_sent = 0;
            while (n_sent < PHASE_TERMS) begin
                face_len = $urandom_range(1, 6);
                for (int k = 0; k < face_len; k++) begin
                    t_edge_term t;
                    t = rand_term(k == face_len - 1);
                    send_term(t);
                    if (fold_edge_term(t, res)) pending_emf.push_back(res);
                    n_sent++;
                end
            end
        end

        // Wind down and report.
        i_in_valid <= 1'b0;
        while (pending_emf.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("conformal_face_circulation_top test passed");
        end else begin
            $display("conformal_face_circulation_top test failed");
        end
        $finish;
    end

endmodule
